// ===== design/pmt_pkg.sv =====
package pmt_pkg;

  // Cursor coordinate width
  localparam int COORD_BITS = 12;
  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

  // Configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0] RST_SCREEN_WIDTH  = 13'd1024;
  localparam logic [CFG_W-1:0] RST_SCREEN_HEIGHT = 13'd768;

  // Header bit positions
  localparam int HDR_LEFT   = 0;
  localparam int HDR_RIGHT  = 1;
  localparam int HDR_MIDDLE = 2;
  localparam int HDR_SYNC   = 3;
  localparam int HDR_SIGN_X = 4;
  localparam int HDR_SIGN_Y = 5;
  localparam int HDR_OVF_X  = 6;
  localparam int HDR_OVF_Y  = 7;

  // Arithmetic widths
  localparam int MOVE_W = 9;
  localparam int LIM_W  = (CFG_W > COORD_BITS) ? CFG_W : COORD_BITS;
  localparam int SUM_W  = LIM_W + 2;

  // Stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_BITS    = 2 * COORD_BITS + 3;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // One complete packet as it crosses the queue
  typedef struct packed {
    logic [7:0] header;
    logic [7:0] x_move;
    logic [7:0] y_move;
  } packet_t;

  // Packet assembly states
  typedef enum logic [2:0] {
    ST_HDR = 3'b001,
    ST_XMV = 3'b010,
    ST_YMV = 3'b100
  } asm_state_t;

endpackage

// ===== design/ps2_mouse_packet_tracker.sv =====
// Channel | Dir | Ports          | Beat contents (low bit first)
// in      | in  | in_t*          | tdata: data_byte[7:0]
// out     | out | out_t*         | tdata: x_position[11:0], y_position[11:0], left, middle, right
// cfg     | in  | cfg_we/addr/wd | 0 screen_width, 1 screen_height (13 bits)
//
// One byte per cycle while in_tready is high; a completed packet passes through the queue
// slot and then the registered cursor add/clamp in the back stage before it shows on out.
// Reset (rst_n low, synchronous) clears packet assembly, queue and cursor, and sets the
// screen size back to 1024 x 768.
// A two-entry packet queue separates assembly from the cursor stage; in_tready drops
// only on a third byte while the queue is full, which happens when out stalls.
module ps2_mouse_packet_tracker import pmt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // data_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // x_position, y_position, left, middle, right
);

  logic    q_push, q_ready, q_pop, q_valid;
  packet_t push_pkt, pop_pkt;

  pmt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_push    (q_push),
    .q_pkt     (push_pkt),
    .q_ready   (q_ready)
  );

  pmt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_pkt   (push_pkt),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_pkt    (pop_pkt),
    .pop_valid  (q_valid)
  );

  pmt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_pkt      (pop_pkt),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // A packet is never pushed into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n) q_push |-> q_ready)
    else $error("packet pushed into full queue");

  // Back stage pops only a present packet
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");

  // A popped packet always lands in the output register
  a_pop_out: assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> out_tvalid)
    else $error("popped packet lost");

  // Input stalls only because the queue is full
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n) !in_tready |-> !q_ready)
    else $error("input stalled with queue room");

endmodule

// ===== design/pmt_front.sv =====
module pmt_front import pmt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  output logic                  q_push,
  output packet_t               q_pkt,
  input  logic                  q_ready
);

  asm_state_t state_r, state_nxt;
  logic [7:0] header_r, header_nxt;
  logic [7:0] x_move_r, x_move_nxt;
  logic       beat;

  // Only the last byte of a packet needs room in the queue
  assign in_tready = (state_r != ST_YMV) || q_ready;
  assign beat      = in_tvalid && in_tready;
  assign q_push    = beat && (state_r == ST_YMV);
  assign q_pkt     = '{header: header_r, x_move: x_move_r, y_move: in_tdata[7:0]};

  // Byte position within the packet
  always_comb begin
    state_nxt  = state_r;
    header_nxt = header_r;
    x_move_nxt = x_move_r;
    unique case (state_r)
      ST_XMV: begin
        if (beat) begin
          x_move_nxt = in_tdata[7:0];
          state_nxt  = ST_YMV;
        end
      end
      ST_YMV: begin
        if (beat) begin
          state_nxt = ST_HDR;
        end
      end
      default: begin
        // header must carry the sync bit, otherwise it is dropped
        if (beat && in_tdata[HDR_SYNC]) begin
          header_nxt = in_tdata[7:0];
          state_nxt  = ST_XMV;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HDR;
    end else begin
      state_r <= state_nxt;
    end
    header_r <= header_nxt;
    x_move_r <= x_move_nxt;
  end

endmodule

// ===== design/pmt_queue.sv =====
module pmt_queue import pmt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  packet_t push_pkt,
  output logic    push_ready,
  input  logic    pop,
  output packet_t pop_pkt,
  output logic    pop_valid
);

  packet_t    slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_pkt    = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_pkt;
    end
  end

endmodule

// ===== design/pmt_back.sv =====
module pmt_back import pmt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   q_valid,
  input  packet_t                q_pkt,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [CFG_W-1:0]       width_r, width_nxt;
  logic [CFG_W-1:0]       height_r, height_nxt;
  logic [COORD_BITS-1:0]  cur_x_r, cur_x_nxt;
  logic [COORD_BITS-1:0]  cur_y_r, cur_y_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [MOVE_W-1:0]     mag_x, mag_y;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic [COORD_BITS-1:0] lim_x, lim_y;

  // Screen size to largest legal coordinate
  function automatic logic [COORD_BITS-1:0] size_to_lim(input logic [CFG_W-1:0] size);
    logic [CFG_W-1:0] m1;
    logic [LIM_W-1:0] full;
    m1   = (size == '0) ? '0 : size - 1'b1;
    full = LIM_W'(m1);
    if (full > LIM_W'(COORD_MAX)) begin
      full = LIM_W'(COORD_MAX);
    end
    return full[COORD_BITS-1:0];
  endfunction

  // Magnitude of one move byte, with the overflow extension
  function automatic logic [MOVE_W-1:0] move_mag(input logic [7:0] b, input logic neg,
                                                 input logic ovf);
    logic [7:0] m;
    m = neg ? (8'd0 - b) : b;
    return {1'b0, m} + (ovf ? MOVE_W'(255) : MOVE_W'(0));
  endfunction

  // Clamp a signed sum into [0, lim]
  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SUM_W-1:0] v,
                                                  input logic [COORD_BITS-1:0] lim);
    logic [COORD_BITS-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({{(SUM_W-COORD_BITS){1'b0}}, lim})) begin
      r = lim;
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  assign q_pop      = q_valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration writes
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_SCREEN_WIDTH:  width_nxt  = cfg_wdata;
        CFG_SCREEN_HEIGHT: height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Cursor update; Y moves against the mouse sign
  always_comb begin
    mag_x = move_mag(q_pkt.x_move, q_pkt.header[HDR_SIGN_X], q_pkt.header[HDR_OVF_X]);
    mag_y = move_mag(q_pkt.y_move, q_pkt.header[HDR_SIGN_Y], q_pkt.header[HDR_OVF_Y]);
    sum_x = $signed({{(SUM_W-COORD_BITS){1'b0}}, cur_x_r});
    sum_y = $signed({{(SUM_W-COORD_BITS){1'b0}}, cur_y_r});
    if (q_pkt.header[HDR_SIGN_X]) begin
      sum_x = sum_x - $signed({{(SUM_W-MOVE_W){1'b0}}, mag_x});
    end else begin
      sum_x = sum_x + $signed({{(SUM_W-MOVE_W){1'b0}}, mag_x});
    end
    if (q_pkt.header[HDR_SIGN_Y]) begin
      sum_y = sum_y + $signed({{(SUM_W-MOVE_W){1'b0}}, mag_y});
    end else begin
      sum_y = sum_y - $signed({{(SUM_W-MOVE_W){1'b0}}, mag_y});
    end
    lim_x = size_to_lim(width_r);
    lim_y = size_to_lim(height_r);
  end

  // Output register and cursor state
  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (q_pop) begin
      cur_x_nxt     = clamp(sum_x, lim_x);
      cur_y_nxt     = clamp(sum_y, lim_y);
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_TDATA_W'({q_pkt.header[HDR_RIGHT], q_pkt.header[HDR_MIDDLE],
                                    q_pkt.header[HDR_LEFT], cur_y_nxt, cur_x_nxt});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= RST_SCREEN_WIDTH;
      height_r    <= RST_SCREEN_HEIGHT;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== verif/tb_ps2_mouse_packet_tracker.sv =====
module tb_ps2_mouse_packet_tracker import pmt_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // One decoded packet as it leaves the block
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  left;
    logic                  middle;
    logic                  right;
  } cursor_report_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr = CFG_SCREEN_WIDTH;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;    // data_byte
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // x_position, y_position, left, middle, right

  ps2_mouse_packet_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // Tracker model state
  asm_state_t pkt_state = ST_HDR;
  logic [7:0] pkt_header = '0;
  logic [7:0] pkt_xmove = '0;
  int         cur_x = 0;
  int         cur_y = 0;
  int         scr_w = int'(RST_SCREEN_WIDTH);
  int         scr_h = int'(RST_SCREEN_HEIGHT);

  logic [7:0]     byte_q[$];
  cursor_report_t pos_expect_q[$];

  int  mismatch_cnt = 0;
  int  bytes_sent = 0;
  int  packets_done = 0;
  int  bytes_dropped = 0;
  int  settings_used = 1;
  logic in_taken = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  rdy_mode = 0;
  int  mode_left = 0;

  // Signed move from one move byte and its sign/overflow header bits
  function automatic int move_of(logic [7:0] b, logic neg, logic ovf);
    int mag;
    mag = neg ? ((256 - int'(b)) & 255) : int'(b);
    if (ovf) mag += 255;
    return neg ? -mag : mag;
  endfunction

  function automatic int clamp_to(int v, int size);
    int lim;
    lim = (size == 0) ? 0 : size - 1;
    if (lim > int'(COORD_MAX)) lim = int'(COORD_MAX);
    if (v < 0) v = 0;
    if (v > lim) v = lim;
    return v;
  endfunction

  // Advance the packet tracker by one accepted byte
  task automatic track_byte(input logic [7:0] b);
    cursor_report_t rep;
    case (pkt_state)
      ST_XMV: begin
        pkt_xmove = b;
        pkt_state = ST_YMV;
      end
      ST_YMV: begin
        pkt_state = ST_HDR;
        cur_x = clamp_to(cur_x + move_of(pkt_xmove, pkt_header[HDR_SIGN_X],
                                         pkt_header[HDR_OVF_X]), scr_w);
        cur_y = clamp_to(cur_y - move_of(b, pkt_header[HDR_SIGN_Y],
                                         pkt_header[HDR_OVF_Y]), scr_h);
        rep.x      = cur_x[COORD_BITS-1:0];
        rep.y      = cur_y[COORD_BITS-1:0];
        rep.left   = pkt_header[HDR_LEFT];
        rep.middle = pkt_header[HDR_MIDDLE];
        rep.right  = pkt_header[HDR_RIGHT];
        pos_expect_q.push_back(rep);
      end
      default: begin
        // no sync bit: byte is thrown away
        if (b[HDR_SYNC]) begin
          pkt_header = b;
          pkt_state  = ST_XMV;
        end else begin
          bytes_dropped++;
        end
      end
    endcase
  endtask

  // Monitor: track input beats, check output beats
  always @(posedge clk) begin : mon
    cursor_report_t got;
    cursor_report_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        track_byte(in_tdata);
        bytes_sent++;
      end
      if (out_tvalid && out_tready) begin
        got.x      = out_tdata[COORD_BITS-1:0];
        got.y      = out_tdata[2*COORD_BITS-1:COORD_BITS];
        got.left   = out_tdata[2*COORD_BITS];
        got.middle = out_tdata[2*COORD_BITS+1];
        got.right  = out_tdata[2*COORD_BITS+2];
        if (pos_expect_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected beat x=%0d y=%0d l=%0b m=%0b r=%0b", $realtime,
                     got.x, got.y, got.left, got.middle, got.right);
        end else begin
          want = pos_expect_q.pop_front();
          packets_done++;
          if (got.x !== want.x || got.y !== want.y || got.left !== want.left ||
              got.middle !== want.middle || got.right !== want.right) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: packet %0d exp x=%0d y=%0d lmr=%b%b%b, got x=%0d y=%0d lmr=%b%b%b",
                       $realtime, packets_done, want.x, want.y, want.left, want.middle,
                       want.right, got.x, got.y, got.left, got.middle, got.right);
          end
        end
      end
    end
  end

  // Byte driver: bursts of random length with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        in_tdata  <= byte_q.pop_front();
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: switches between always ready, coin flip and heavy stall
  always @(negedge clk) begin
    if (mode_left == 0) begin
      rdy_mode  <= $urandom_range(0, 2);
      mode_left <= $urandom_range(20, 80);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rdy_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  task automatic push_packet(input logic [7:0] hdr, input logic [7:0] xb,
                             input logic [7:0] yb);
    byte_q.push_back(hdr);
    byte_q.push_back(xb);
    byte_q.push_back(yb);
  endtask

  // Mostly well-formed packets, some stray bytes that break the framing
  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 2)) byte_q.push_back(8'($urandom_range(0, 255)));
      end
      push_packet(8'($urandom_range(0, 255)) | (8'h1 << HDR_SYNC),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  // Let the byte queue drain and every result come back, then wait quietly
  task automatic settle();
    while (byte_q.size() != 0 || in_tvalid) @(negedge clk);
    while (pos_expect_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_screen(input int w, input int h);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_SCREEN_WIDTH;
    cfg_wdata <= w[CFG_W-1:0];
    @(negedge clk);
    cfg_addr  <= CFG_SCREEN_HEIGHT;
    cfg_wdata <= h[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    scr_w = w;
    scr_h = h;
    settings_used++;
  endtask

  initial begin : stim
    int w_set[10];
    int h_set[10];
    w_set = '{4096, 8191, 1, 0, 4096, 640, 1023, 8191, 0, 0};
    h_set = '{4096, 8191, 4096, 0, 1, 480, 2, 1, 0, 0};
    w_set[8] = $urandom_range(0, 8191);
    h_set[8] = $urandom_range(0, 8191);
    w_set[9] = $urandom_range(1, 300);
    h_set[9] = $urandom_range(1, 300);

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: bytes without sync, sign/overflow cases, buttons
    byte_q.push_back(8'h00);
    byte_q.push_back(8'hF7);
    push_packet(8'h08, 8'hFF, 8'h00);   // x +255
    push_packet(8'h48, 8'hFF, 8'h00);   // x overflow, +510
    push_packet(8'h48, 8'hFF, 8'h00);   // runs past the right edge
    push_packet(8'h18, 8'h00, 8'h00);   // negative x of zero magnitude
    push_packet(8'h28, 8'h01, 8'h80);   // y sign: cursor moves down 128
    push_packet(8'h8F, 8'h7F, 8'hFF);   // buttons, y overflow up past top
    push_packet(8'hFF, 8'h01, 8'h01);   // all header bits, far left and down
    push_packet(8'h59, 8'h80, 8'h00);   // x overflow negative, moves left 383
    settle();

    for (int p = 0; p < 10; p++) begin
      write_screen(w_set[p], h_set[p]);
      push_random(25);
      settle();
    end

    $display("Sent %0d bytes (%0d without sync dropped), checked %0d packets",
             bytes_sent, bytes_dropped, packets_done);
    $display("across %0d screen sizes, with %0d mismatches", settings_used, mismatch_cnt);
    if (mismatch_cnt == 0 && pos_expect_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d packets outstanding", pos_expect_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
